// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the checker files.
// Needs a clock, and for TCH_ASSERT an active-low reset, passed in by the caller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is asserted.
`define TCH_ASSERT(label, clk_s, rst_n, prop, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n) prop) \
		else $error(msg);

// Clocked assertion that also holds during reset.
`define TCH_ASSERT_ALWAYS(label, clk_s, prop, msg) \
	label: assert property (@(posedge clk_s) prop) \
		else $error(msg);

`endif

// File: hw/rtl/tch_pkg.sv
// Shared constants, types and tables for the tilt-compensated heading unit.
// No dependencies.
package tch_pkg;

	localparam int ANGLE_FRAC_BITS   = 13;
	localparam int HEADING_FRAC_BITS = 14;

	localparam int FW   = 16;
	localparam int BW   = FW + 1;
	localparam int OUTW = 16;

	// angle path, Q30 radians
	localparam int AW = 36;
	localparam logic signed [AW-1:0] Q30_TWO_PI  = 36'sd6746518852;
	localparam logic signed [AW-1:0] Q30_PI      = 36'sd3373259426;
	localparam logic signed [AW-1:0] Q30_HALF_PI = 36'sd1686629713;

	// CORDIC
	localparam int CW            = 34;
	localparam int CORDIC_ITERS  = 30;
	localparam int CORDIC_PER    = 5;
	localparam int CORDIC_STAGES = (CORDIC_ITERS + CORDIC_PER - 1) / CORDIC_PER;
	localparam int CORDIC_LAT    = CORDIC_STAGES + 3;
	localparam logic signed [CW-1:0] CORDIC_GAIN_INV = 34'sd652032874;

	// projection
	localparam int PW   = 2 * CW;
	localparam int TW   = BW + CW;
	localparam int HW   = TW + 2;
	localparam int MAGW = 31;
	localparam int SHW  = $clog2(HW - MAGW + 1);

	// square root
	localparam int ROOTW     = 32;
	localparam int SQ_PER    = 4;
	localparam int SQ_STAGES = ROOTW / SQ_PER;
	localparam int REMW      = ROOTW + 4;
	localparam int RADW      = 2 * ROOTW;

	// divider
	localparam int QN         = HEADING_FRAC_BITS + 1;
	localparam int DIVW       = HEADING_FRAC_BITS + 34;
	localparam int DIV_PER    = 3;
	localparam int DIV_STAGES = (QN + DIV_PER - 1) / DIV_PER;

	// register file
	localparam int ADDRW = 4;
	localparam int DATAW = 32;

	typedef enum logic [1:0] {
		REG_BIAS_X = 2'd0,
		REG_BIAS_Y = 2'd1,
		REG_BIAS_Z = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [MAGW-1:0] ax;
		logic [MAGW-1:0] ay;
		logic            neg_x;
		logic            neg_y;
		logic            degen;
	} norm_in_t;

	function automatic logic signed [CW-1:0] atan_q30(input int i);
		logic signed [CW-1:0] r;
		case (i)
			0:  r = 34'sh3243F6A8;
			1:  r = 34'sh1DAC6705;
			2:  r = 34'sh0FADBAFC;
			3:  r = 34'sh07F56EA6;
			4:  r = 34'sh03FEAB76;
			5:  r = 34'sh01FFD55B;
			6:  r = 34'sh00FFFAAA;
			7:  r = 34'sh007FFF55;
			8:  r = 34'sh003FFFEA;
			9:  r = 34'sh001FFFFD;
			10: r = 34'sh000FFFFF;
			11: r = 34'sh0007FFFF;
			12: r = 34'sh0003FFFF;
			13: r = 34'sh0001FFFF;
			14: r = 34'sh0000FFFF;
			15: r = 34'sh00007FFF;
			16: r = 34'sh00003FFF;
			17: r = 34'sh00001FFF;
			18: r = 34'sh00000FFF;
			19: r = 34'sh000007FF;
			20: r = 34'sh000003FF;
			21: r = 34'sh000001FF;
			22: r = 34'sh000000FF;
			23: r = 34'sh0000007F;
			24: r = 34'sh0000003F;
			25: r = 34'sh0000001F;
			26: r = 34'sh0000000F;
			27: r = 34'sh00000008;
			28: r = 34'sh00000004;
			29: r = 34'sh00000002;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// File: hw/rtl/tch_cordic.sv
// Pipelined sine/cosine: angle wrap and fold, then rotation-mode CORDIC.
// Depends on tch_pkg.
module tch_cordic (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          in_vld,
	input  logic signed [tch_pkg::FW-1:0] angle,
	output logic                          out_vld,
	output logic signed [tch_pkg::CW-1:0] sin_val,
	output logic signed [tch_pkg::CW-1:0] cos_val
);
	import tch_pkg::*;

	logic signed [AW-1:0] a_ext, a_wrap, a_s1, z_fold;
	logic                 neg_fold;
	logic                 v_s1;

	logic [CORDIC_STAGES:0] v_c;
	logic signed [CW-1:0]   x_c [0:CORDIC_STAGES];
	logic signed [CW-1:0]   y_c [0:CORDIC_STAGES];
	logic signed [CW-1:0]   z_c [0:CORDIC_STAGES];
	logic                   neg_c [0:CORDIC_STAGES];
	logic signed [CW-1:0]   nx [0:CORDIC_STAGES-1];
	logic signed [CW-1:0]   ny [0:CORDIC_STAGES-1];
	logic signed [CW-1:0]   nz [0:CORDIC_STAGES-1];

	// wrap into (-pi, pi]
	always_comb begin
		a_ext = AW'(angle) <<< (30 - ANGLE_FRAC_BITS);
		if (a_ext > Q30_PI) begin
			a_wrap = a_ext - Q30_TWO_PI;
		end else if (a_ext <= -Q30_PI) begin
			a_wrap = a_ext + Q30_TWO_PI;
		end else begin
			a_wrap = a_ext;
		end
	end

	// fold into [-pi/2, pi/2], negate both outputs at the end
	always_comb begin
		z_fold   = a_s1;
		neg_fold = 1'b0;
		if (a_s1 > Q30_HALF_PI) begin
			z_fold   = a_s1 - Q30_PI;
			neg_fold = 1'b1;
		end else if (a_s1 < -Q30_HALF_PI) begin
			z_fold   = a_s1 + Q30_PI;
			neg_fold = 1'b1;
		end
	end

	always_comb begin
		logic signed [CW-1:0] tx, ty, tz, dx, dy;
		int it;
		for (int g = 0; g < CORDIC_STAGES; g++) begin
			tx = x_c[g];
			ty = y_c[g];
			tz = z_c[g];
			for (int j = 0; j < CORDIC_PER; j++) begin
				it = g * CORDIC_PER + j;
				if (it < CORDIC_ITERS) begin
					dx = ty >>> it;
					dy = tx >>> it;
					if (!tz[CW-1]) begin
						tx = tx - dx;
						ty = ty + dy;
						tz = tz - atan_q30(it);
					end else begin
						tx = tx + dx;
						ty = ty - dy;
						tz = tz + atan_q30(it);
					end
				end
			end
			nx[g] = tx;
			ny[g] = ty;
			nz[g] = tz;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_c     <= '0;
			out_vld <= 1'b0;
		end else if (adv) begin
			v_s1    <= in_vld;
			v_c     <= {v_c[CORDIC_STAGES-1:0], v_s1};
			out_vld <= v_c[CORDIC_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s1     <= a_wrap;
			x_c[0]   <= CORDIC_GAIN_INV;
			y_c[0]   <= '0;
			z_c[0]   <= CW'(z_fold);
			neg_c[0] <= neg_fold;
			for (int g = 0; g < CORDIC_STAGES; g++) begin
				x_c[g+1]   <= nx[g];
				y_c[g+1]   <= ny[g];
				z_c[g+1]   <= nz[g];
				neg_c[g+1] <= neg_c[g];
			end
			sin_val <= neg_c[CORDIC_STAGES] ? -y_c[CORDIC_STAGES] : y_c[CORDIC_STAGES];
			cos_val <= neg_c[CORDIC_STAGES] ? -x_c[CORDIC_STAGES] : x_c[CORDIC_STAGES];
		end
	end

endmodule

// File: hw/rtl/tch_norm.sv
// Normalizer: magnitude by pipelined square root, then two pipelined
// restoring dividers for the unit components. Depends on tch_pkg.
module tch_norm (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            adv,
	input  logic                            in_vld,
	input  tch_pkg::norm_in_t               in_data,
	output logic                            out_vld,
	output logic signed [tch_pkg::OUTW-1:0] heading_x,
	output logic signed [tch_pkg::OUTW-1:0] heading_y,
	output logic                            degenerate
);
	import tch_pkg::*;

	logic [2*MAGW-1:0] sqx_s1, sqy_s1;
	norm_in_t          side_s1;
	logic              v_s1;

	logic [SQ_STAGES:0] v_sq;
	logic [RADW-1:0]    rad_p  [0:SQ_STAGES];
	logic [REMW-1:0]    rem_p  [0:SQ_STAGES];
	logic [ROOTW-1:0]   root_p [0:SQ_STAGES];
	norm_in_t           side_p [0:SQ_STAGES];
	logic [RADW-1:0]    nrad   [0:SQ_STAGES-1];
	logic [REMW-1:0]    nrem   [0:SQ_STAGES-1];
	logic [ROOTW-1:0]   nroot  [0:SQ_STAGES-1];

	logic [DIV_STAGES:0] v_dv;
	logic [DIVW-1:0]     rx_p [0:DIV_STAGES];
	logic [DIVW-1:0]     ry_p [0:DIV_STAGES];
	logic [DIVW-1:0]     dv_p [0:DIV_STAGES];
	logic [QN-1:0]       qx_p [0:DIV_STAGES];
	logic [QN-1:0]       qy_p [0:DIV_STAGES];
	norm_in_t            sd_p [0:DIV_STAGES];
	logic [DIVW-1:0]     nrx  [0:DIV_STAGES-1];
	logic [DIVW-1:0]     nry  [0:DIV_STAGES-1];
	logic [QN-1:0]       nqx  [0:DIV_STAGES-1];
	logic [QN-1:0]       nqy  [0:DIV_STAGES-1];

	logic [ROOTW-1:0] mag;
	logic [OUTW-1:0]  ux, uy;

	// digit-by-digit square root, two radicand bits per step
	always_comb begin
		logic [RADW-1:0]  tv;
		logic [REMW-1:0]  tr, trial;
		logic [ROOTW-1:0] tq;
		for (int g = 0; g < SQ_STAGES; g++) begin
			tv = rad_p[g];
			tr = rem_p[g];
			tq = root_p[g];
			for (int j = 0; j < SQ_PER; j++) begin
				tr    = {tr[REMW-3:0], tv[RADW-1:RADW-2]};
				tv    = tv << 2;
				trial = REMW'({tq, 2'b01});
				if (tr >= trial) begin
					tr = tr - trial;
					tq = {tq[ROOTW-2:0], 1'b1};
				end else begin
					tq = {tq[ROOTW-2:0], 1'b0};
				end
			end
			nrad[g]  = tv;
			nrem[g]  = tr;
			nroot[g] = tq;
		end
	end

	assign mag = root_p[SQ_STAGES];

	// restoring division, quotient bits from the top
	always_comb begin
		logic [DIVW-1:0] tx, ty, sh;
		logic [QN-1:0]   tqx, tqy;
		int t, k;
		for (int g = 0; g < DIV_STAGES; g++) begin
			tx  = rx_p[g];
			ty  = ry_p[g];
			tqx = qx_p[g];
			tqy = qy_p[g];
			for (int j = 0; j < DIV_PER; j++) begin
				t = g * DIV_PER + j;
				if (t < QN) begin
					k  = QN - 1 - t;
					sh = dv_p[g] << k;
					if (tx >= sh) begin
						tx     = tx - sh;
						tqx[k] = 1'b1;
					end
					if (ty >= sh) begin
						ty     = ty - sh;
						tqy[k] = 1'b1;
					end
				end
			end
			nrx[g] = tx;
			nry[g] = ty;
			nqx[g] = tqx;
			nqy[g] = tqy;
		end
	end

	assign ux = OUTW'(qx_p[DIV_STAGES]);
	assign uy = OUTW'(qy_p[DIV_STAGES]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_sq    <= '0;
			v_dv    <= '0;
			out_vld <= 1'b0;
		end else if (adv) begin
			v_s1    <= in_vld;
			v_sq    <= {v_sq[SQ_STAGES-1:0], v_s1};
			v_dv    <= {v_dv[DIV_STAGES-1:0], v_sq[SQ_STAGES]};
			out_vld <= v_dv[DIV_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sqx_s1  <= in_data.ax * in_data.ax;
			sqy_s1  <= in_data.ay * in_data.ay;
			side_s1 <= in_data;

			rad_p[0]  <= RADW'(sqx_s1) + RADW'(sqy_s1);
			rem_p[0]  <= '0;
			root_p[0] <= '0;
			side_p[0] <= side_s1;
			for (int g = 0; g < SQ_STAGES; g++) begin
				rad_p[g+1]  <= nrad[g];
				rem_p[g+1]  <= nrem[g];
				root_p[g+1] <= nroot[g];
				side_p[g+1] <= side_p[g];
			end

			// numerator carries half the divisor for round half up
			rx_p[0] <= (DIVW'(side_p[SQ_STAGES].ax) << QN) + DIVW'(mag);
			ry_p[0] <= (DIVW'(side_p[SQ_STAGES].ay) << QN) + DIVW'(mag);
			dv_p[0] <= DIVW'(mag) << 1;
			qx_p[0] <= '0;
			qy_p[0] <= '0;
			sd_p[0] <= side_p[SQ_STAGES];
			for (int g = 0; g < DIV_STAGES; g++) begin
				rx_p[g+1] <= nrx[g];
				ry_p[g+1] <= nry[g];
				dv_p[g+1] <= dv_p[g];
				qx_p[g+1] <= nqx[g];
				qy_p[g+1] <= nqy[g];
				sd_p[g+1] <= sd_p[g];
			end

			if (sd_p[DIV_STAGES].degen) begin
				heading_x  <= '0;
				heading_y  <= '0;
				degenerate <= 1'b1;
			end else begin
				heading_x  <= sd_p[DIV_STAGES].neg_x ? -ux : ux;
				heading_y  <= sd_p[DIV_STAGES].neg_y ? -uy : uy;
				degenerate <= 1'b0;
			end
		end
	end

endmodule

// File: hw/rtl/tilt_compensated_heading_unit.sv
// Tilt-compensated compass heading unit, top level.
// Depends on tch_pkg, tch_cordic and tch_norm.
//
// Usage:
//   Input channel (in_valid/in_stall) takes one word per cycle: raw field
//   x/y/z and roll/pitch angles (Q3.13 radians). Output channel
//   (out_valid/out_stall) returns the unit heading vector (x, -y) in Q1.14
//   and a degenerate flag, set with a zero vector when the horizontal
//   field is exactly zero.
//   Bias registers (x, y, z at byte offsets 0, 4, 8) are written over the
//   APB port; write them only while no word is in flight.
//   Throughput is one word per cycle while in_stall is low: 30 CORDIC
//   iterations, 32 square-root steps and 15 quotient bits are each spread
//   over their own register stages.
//   The whole pipeline advances together; it holds only while a result
//   sits in the output register with out_stall high, and in_stall is high
//   in exactly those cycles. Bubbles travel as cleared valid bits.
//   Reset clears all valid bits and the bias registers to zero.
module tilt_compensated_heading_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [tch_pkg::ADDRW-1:0]         paddr,
	input  logic [tch_pkg::DATAW-1:0]         pwdata,
	output logic [tch_pkg::DATAW-1:0]         prdata,
	output logic                              pready,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [tch_pkg::FW-1:0]     field_x,
	input  logic signed [tch_pkg::FW-1:0]     field_y,
	input  logic signed [tch_pkg::FW-1:0]     field_z,
	input  logic signed [tch_pkg::FW-1:0]     roll_angle,
	input  logic signed [tch_pkg::FW-1:0]     pitch_angle,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [tch_pkg::OUTW-1:0]   heading_x,
	output logic signed [tch_pkg::OUTW-1:0]   heading_y,
	output logic                              degenerate
);
	import tch_pkg::*;

	logic adv;
	logic wr_en;

	logic signed [FW-1:0] bias_x_q, bias_y_q, bias_z_q;

	logic signed [BW-1:0] mx_d [0:CORDIC_LAT-1];
	logic signed [BW-1:0] my_d [0:CORDIC_LAT-1];
	logic signed [BW-1:0] mz_d [0:CORDIC_LAT-1];

	logic                 vr, vp;
	logic signed [CW-1:0] sr, cr, sp, cp;

	logic                 v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic signed [PW-1:0] srsp_p_s1, crsp_p_s1;
	logic signed [CW-1:0] sr_s1, cr_s1, cp_s1;
	logic signed [BW-1:0] mx_s1, my_s1, mz_s1;
	logic signed [PW-1:0] srsp_rnd, crsp_rnd;
	logic signed [CW-1:0] srsp_s2, crsp_s2, sr_s2, cr_s2, cp_s2;
	logic signed [BW-1:0] mx_s2, my_s2, mz_s2;
	logic signed [TW-1:0] t1_s3, t2_s3, t3_s3, t4_s3, t5_s3;
	logic signed [HW-1:0] hx_s4, hy_s4;
	logic [HW-1:0]        abx_s5, aby_s5, abx_s6, aby_s6, abs_or;
	logic                 negx_s5, negy_s5, degen_s5, negx_s6, negy_s6, degen_s6;
	logic [SHW-1:0]       sh_calc, sh_s6;
	norm_in_t             norm_s7;

	assign pready   = 1'b1;
	assign wr_en    = psel && penable && pwrite;
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_x_q <= '0;
			bias_y_q <= '0;
			bias_z_q <= '0;
		end else if (wr_en) begin
			unique case (reg_idx_t'(paddr[3:2]))
				REG_BIAS_X: bias_x_q <= pwdata[FW-1:0];
				REG_BIAS_Y: bias_y_q <= pwdata[FW-1:0];
				REG_BIAS_Z: bias_z_q <= pwdata[FW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[3:2]))
			REG_BIAS_X: prdata = DATAW'(unsigned'(bias_x_q));
			REG_BIAS_Y: prdata = DATAW'(unsigned'(bias_y_q));
			REG_BIAS_Z: prdata = DATAW'(unsigned'(bias_z_q));
			default:    prdata = '0;
		endcase
	end

	tch_cordic u_roll (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_vld  (in_valid),
		.angle   (roll_angle),
		.out_vld (vr),
		.sin_val (sr),
		.cos_val (cr)
	);

	tch_cordic u_pitch (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_vld  (in_valid),
		.angle   (pitch_angle),
		.out_vld (vp),
		.sin_val (sp),
		.cos_val (cp)
	);

	// rounding of the sine products to Q30
	assign srsp_rnd = (srsp_p_s1 + PW'(64'sd536870912)) >>> 30;
	assign crsp_rnd = (crsp_p_s1 + PW'(64'sd536870912)) >>> 30;

	// smallest shift that brings both magnitudes below 2^31
	assign abs_or = abx_s5 | aby_s5;
	always_comb begin
		sh_calc = '0;
		for (int p = MAGW; p < HW; p++) begin
			if (abs_or[p]) begin
				sh_calc = SHW'(p - MAGW + 1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s1 <= vr && vp;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// biased field rides alongside the CORDIC
			mx_d[0] <= BW'(field_x) + BW'(bias_x_q);
			my_d[0] <= BW'(field_y) + BW'(bias_y_q);
			mz_d[0] <= BW'(field_z) + BW'(bias_z_q);
			for (int k = 1; k < CORDIC_LAT; k++) begin
				mx_d[k] <= mx_d[k-1];
				my_d[k] <= my_d[k-1];
				mz_d[k] <= mz_d[k-1];
			end

			srsp_p_s1 <= sr * sp;
			crsp_p_s1 <= cr * sp;
			sr_s1     <= sr;
			cr_s1     <= cr;
			cp_s1     <= cp;
			mx_s1     <= mx_d[CORDIC_LAT-1];
			my_s1     <= my_d[CORDIC_LAT-1];
			mz_s1     <= mz_d[CORDIC_LAT-1];

			srsp_s2 <= srsp_rnd[CW-1:0];
			crsp_s2 <= crsp_rnd[CW-1:0];
			sr_s2   <= sr_s1;
			cr_s2   <= cr_s1;
			cp_s2   <= cp_s1;
			mx_s2   <= mx_s1;
			my_s2   <= my_s1;
			mz_s2   <= mz_s1;

			t1_s3 <= mx_s2 * cp_s2;
			t2_s3 <= my_s2 * srsp_s2;
			t3_s3 <= mz_s2 * crsp_s2;
			t4_s3 <= my_s2 * cr_s2;
			t5_s3 <= mz_s2 * sr_s2;

			hx_s4 <= HW'(t1_s3) + HW'(t2_s3) + HW'(t3_s3);
			hy_s4 <= HW'(t4_s3) - HW'(t5_s3);

			abx_s5   <= hx_s4[HW-1] ? HW'(-hx_s4) : HW'(hx_s4);
			aby_s5   <= hy_s4[HW-1] ? HW'(-hy_s4) : HW'(hy_s4);
			negx_s5  <= hx_s4[HW-1];
			negy_s5  <= !hy_s4[HW-1] && (hy_s4 != '0);
			degen_s5 <= (hx_s4 == '0) && (hy_s4 == '0);

			sh_s6    <= sh_calc;
			abx_s6   <= abx_s5;
			aby_s6   <= aby_s5;
			negx_s6  <= negx_s5;
			negy_s6  <= negy_s5;
			degen_s6 <= degen_s5;

			norm_s7.ax    <= MAGW'(abx_s6 >> sh_s6);
			norm_s7.ay    <= MAGW'(aby_s6 >> sh_s6);
			norm_s7.neg_x <= negx_s6;
			norm_s7.neg_y <= negy_s6;
			norm_s7.degen <= degen_s6;
		end
	end

	tch_norm u_norm (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.in_vld     (v_s7),
		.in_data    (norm_s7),
		.out_vld    (out_valid),
		.heading_x  (heading_x),
		.heading_y  (heading_y),
		.degenerate (degenerate)
	);

endmodule

// File: hw/rtl/tch_checker.sv
// Port-level checker for the heading unit, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module tch_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [15:0] heading_x,
	input logic signed [15:0] heading_y,
	input logic               degenerate
);

	`TCH_ASSERT(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid && $stable(heading_x) && $stable(heading_y) && $stable(degenerate), "stalled output word changed")

	`TCH_ASSERT(a_degen_zero, clk, arst_n, out_valid && degenerate |-> heading_x == 16'sd0 && heading_y == 16'sd0, "degenerate word with nonzero heading")

	`TCH_ASSERT(a_unit_range, clk, arst_n, out_valid && !degenerate |-> heading_x <= 16'sd16384 && heading_x >= -16'sd16384 && heading_y <= 16'sd16384 && heading_y >= -16'sd16384, "heading component beyond unit range")

	`TCH_ASSERT(a_unit_nonzero, clk, arst_n, out_valid && !degenerate |-> heading_x != 16'sd0 || heading_y != 16'sd0, "zero heading without degenerate flag")

endmodule

bind tilt_compensated_heading_unit tch_checker u_tch_checker (.*);

// File: sim/tb.sv
// Self-checking testbench for tilt_compensated_heading_unit.
// Runs directed and random field/angle words through the bias settings and checks
// each heading against an internal bit-exact predictor. Needs tch_pkg and the RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tch_pkg::*;

	typedef struct packed {
		logic signed [15:0] fx, fy, fz, roll, pitch;
	} sample_t;

	typedef struct packed {
		logic [15:0] hx, hy;
		logic        degen;
	} heading_t;

	localparam longint TWO_PI = 64'sd6746518852;
	localparam longint PI     = 64'sd3373259426;
	localparam longint HALF_PI = 64'sd1686629713;
	localparam longint GAIN_INV = 64'sd652032874;
	localparam longint ARCTAN [30] = '{
		'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
		'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
		'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
		'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F,
		'h0000003F, 'h0000001F, 'h0000000F, 'h00000008, 'h00000004, 'h00000002};

	logic clk = 0, arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [ADDRW-1:0] paddr = '0;
	logic [DATAW-1:0] pwdata = '0, prdata;
	logic pready;
	logic in_valid = 0, in_stall;
	logic signed [15:0] field_x = 0, field_y = 0, field_z = 0, roll_angle = 0, pitch_angle = 0;
	logic out_valid, out_stall = 0;
	logic signed [15:0] heading_x, heading_y;
	logic degenerate;

	sample_t  pending_words[$];
	heading_t headings_due[$];
	logic signed [15:0] bx = 0, by = 0, bz = 0;
	int errors = 0, checked = 0, degen_seen = 0;
	int idle_pct = 10, hold_ask = 0, hold_seen = 0, hold_cnt = 0;

	tilt_compensated_heading_unit DUT (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	function automatic void sin_cos(input logic signed [15:0] raw, output longint s,
			output longint c);
		longint a, x, y, z, dx, dy;
		bit neg;
		a = longint'(raw) * (64'sd1 << (30 - ANGLE_FRAC_BITS));
		neg = 0;
		a = a % TWO_PI;
		if (a > PI) a -= TWO_PI;
		else if (a <= -PI) a += TWO_PI;
		if (a > HALF_PI) begin
			a -= PI;
			neg = 1;
		end else if (a < -HALF_PI) begin
			a += PI;
			neg = 1;
		end
		x = GAIN_INV;
		y = 0;
		z = a;
		for (int i = 0; i < 30; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= ARCTAN[i];
			end else begin
				x += dx; y -= dy; z += ARCTAN[i];
			end
		end
		s = neg ? -y : y;
		c = neg ? -x : x;
	endfunction

	function automatic longint unsigned root_floor(input longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else
				r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	function automatic heading_t heading_of(input sample_t w);
		heading_t h;
		longint mx, my, mz, sr, cr, sp, cp, srsp, crsp, hx, hy;
		longint unsigned ax, ay, top, mag, qx, qy;
		int s;
		mx = longint'(w.fx) + longint'(bx);
		my = longint'(w.fy) + longint'(by);
		mz = longint'(w.fz) + longint'(bz);
		sin_cos(w.roll, sr, cr);
		sin_cos(w.pitch, sp, cp);
		srsp = (sr * sp + (64'sd1 << 29)) >>> 30;
		crsp = (cr * sp + (64'sd1 << 29)) >>> 30;
		hx = mx * cp + my * srsp + mz * crsp;
		hy = my * cr - mz * sr;
		if (hx == 0 && hy == 0) return '{hx: 16'd0, hy: 16'd0, degen: 1'b1};
		ax = hx < 0 ? -hx : hx;
		ay = hy < 0 ? -hy : hy;
		top = ax > ay ? ax : ay;
		s = 0;
		while ((top >> s) >= (64'd1 << 31)) s++;
		ax >>= s;
		ay >>= s;
		mag = root_floor(ax * ax + ay * ay);
		qx = ((ax << (HEADING_FRAC_BITS + 1)) + mag) / (mag << 1);
		qy = ((ay << (HEADING_FRAC_BITS + 1)) + mag) / (mag << 1);
		if (hx < 0) qx = -qx;
		if (hy > 0) qy = -qy;
		h.hx = qx[15:0];
		h.hy = qy[15:0];
		h.degen = 1'b0;
		return h;
	endfunction

	// driver: predict on accept, then offer the next word or idle
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				headings_due.push_back(heading_of({field_x, field_y, field_z, roll_angle,
					pitch_angle}));
			if (!in_valid || !in_stall) begin
				if (pending_words.size() > 0 && $urandom_range(99) >= idle_pct) begin
					sample_t w;
					w = pending_words.pop_front();
					{field_x, field_y, field_z, roll_angle, pitch_angle} <= w;
					in_valid <= 1;
				end else
					in_valid <= 0;
			end
		end
	end

	// receiver stall: random, with a long hold-off when the test asks for one
	always @(posedge clk) begin
		if (hold_ask != hold_seen) begin
			hold_seen <= hold_ask;
			hold_cnt <= 300;
			out_stall <= 1;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			out_stall <= 1;
		end else
			out_stall <= ($urandom_range(99) < idle_pct);
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			heading_t e;
			if (headings_due.size() == 0) begin
				$display("%0t: unexpected word hx=%0d hy=%0d degen=%0b", $time, heading_x,
					heading_y, degenerate);
				errors++;
			end else begin
				e = headings_due.pop_front();
				checked++;
				if (e.degen) degen_seen++;
				if (heading_x !== e.hx) begin
					$display("%0t: heading_x exp %0d got %0d", $time, $signed(e.hx), heading_x);
					errors++;
				end
				if (heading_y !== e.hy) begin
					$display("%0t: heading_y exp %0d got %0d", $time, $signed(e.hy), heading_y);
					errors++;
				end
				if (degenerate !== e.degen) begin
					$display("%0t: degenerate exp %0b got %0b", $time, e.degen, degenerate);
					errors++;
				end
			end
		end
	end

	task automatic reg_write(input reg_idx_t idx, input logic [15:0] v);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1;
		paddr <= ADDRW'(4 * int'(idx));
		pwdata <= {16'($urandom_range(65535)), v};
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		case (idx)
			REG_BIAS_X: bx = v;
			REG_BIAS_Y: by = v;
			REG_BIAS_Z: bz = v;
			default: ;
		endcase
	endtask

	task automatic drain();
		wait (pending_words.size() == 0 && !in_valid && headings_due.size() == 0);
		repeat (40) @(posedge clk);
	endtask

	function automatic logic signed [15:0] pick_angle();
		if ($urandom_range(9) == 0) return 16'($urandom());
		return 16'($signed($urandom_range(51472)) - 25736);
	endfunction

	task automatic add_random(input int n);
		sample_t w;
		repeat (n) begin
			w.fx = 16'($urandom());
			w.fy = 16'($urandom());
			w.fz = 16'($urandom());
			if ($urandom_range(3) == 0) begin
				w.fx = 16'($signed($urandom_range(8)) - 4);
				w.fy = 16'($signed($urandom_range(8)) - 4);
			end
			if ($urandom_range(19) == 0) begin
				// cancel the bias to force a zero field (not for a bias of -32768)
				w.fx = -bx; w.fy = -by; w.fz = -bz;
			end
			w.roll = pick_angle();
			w.pitch = pick_angle();
			pending_words.push_back(w);
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1;
		// directed: extremes, zero field, wrap, quarter turns
		pending_words.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
		pending_words.push_back('{16'sd0, 16'sd0, 16'sd1234, 16'sd0, 16'sd0});
		pending_words.push_back('{16'sd32767, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
		pending_words.push_back('{-16'sd32768, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
		pending_words.push_back('{16'sd0, 16'sd32767, 16'sd0, 16'sd0, 16'sd0});
		pending_words.push_back('{16'sd0, -16'sd32768, 16'sd0, 16'sd0, 16'sd0});
		pending_words.push_back('{16'sd32767, 16'sd32767, 16'sd32767, 16'sd25736, 16'sd25736});
		pending_words.push_back('{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd25736,
			-16'sd25736});
		pending_words.push_back('{16'sd100, 16'sd200, 16'sd300, 16'sd12868, -16'sd12868});
		pending_words.push_back('{16'sd100, 16'sd200, 16'sd300, 16'sd32767, -16'sd32768});
		pending_words.push_back('{16'sd5, -16'sd7, 16'sd9, -16'sd32768, 16'sd32767});
		pending_words.push_back('{16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
		pending_words.push_back('{16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd0});
		pending_words.push_back('{16'sd3000, -16'sd4000, 16'sd0, 16'sd6434, 16'sd19302});
		add_random(200);
		drain();
		reg_write(REG_BIAS_X, 16'h7FFF);
		reg_write(REG_BIAS_Y, 16'h8000);
		reg_write(REG_BIAS_Z, 16'h7FFF);
		add_random(220);
		drain();
		reg_write(REG_BIAS_X, 16'h8000);
		reg_write(REG_BIAS_Y, 16'h7FFF);
		reg_write(REG_BIAS_Z, 16'h8000);
		// address past the last register must be ignored
		reg_write(reg_idx_t'(2'd3), 16'h1234);
		add_random(220);
		drain();
		reg_write(REG_BIAS_X, 16'($urandom()));
		reg_write(REG_BIAS_Y, 16'($urandom()));
		reg_write(REG_BIAS_Z, 16'($urandom()));
		idle_pct = 0;
		add_random(220);
		repeat (20) @(posedge clk);
		hold_ask = hold_ask + 1;
		drain();
		idle_pct = 10;
		reg_write(REG_BIAS_X, 16'($urandom()));
		reg_write(REG_BIAS_Y, 16'($urandom()));
		reg_write(REG_BIAS_Z, 16'($urandom()));
		add_random(220);
		drain();
		$display("checked %0d headings (%0d zero-field) over five bias settings", checked,
			degen_seen);
		$display("with random stalls, a no-idle phase and a 300-cycle output hold-off");
		if (errors == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

	initial begin
		#5ms;
		$display("tb failed");
		$finish;
	end
endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/tch_pkg.sv
hw/rtl/tch_cordic.sv
hw/rtl/tch_norm.sv
hw/rtl/tilt_compensated_heading_unit.sv
hw/rtl/tch_checker.sv
sim/tb.sv
